[src/qlbc_pkg.sv]
// ----------------------------------------------------------------------------
// qlbc_pkg: shared types and constants for the QASM lexer with bracket check
// Token kinds, error codes, lexer modes, character codes and the token
// result record.
// ----------------------------------------------------------------------------
package qlbc_pkg;

    // Lexer mode while a token may still be growing
    typedef enum logic [3:0]
    {
        M_IDLE,
        M_NAME,
        M_INT,
        M_REAL,
        M_MINUS,
        M_SLASH,
        M_GT,
        M_LT,
        M_EQ,
        M_COMMENT
    } lex_mode_t;

    // Token kinds
    localparam logic [4:0] K_NAME   = 5'd0;
    localparam logic [4:0] K_INT    = 5'd1;
    localparam logic [4:0] K_REAL   = 5'd2;
    localparam logic [4:0] K_SEMI   = 5'd3;
    localparam logic [4:0] K_LPAR   = 5'd4;
    localparam logic [4:0] K_RPAR   = 5'd5;
    localparam logic [4:0] K_LBRACK = 5'd6;
    localparam logic [4:0] K_RBRACK = 5'd7;
    localparam logic [4:0] K_LBRACE = 5'd8;
    localparam logic [4:0] K_RBRACE = 5'd9;
    localparam logic [4:0] K_COMMA  = 5'd10;
    localparam logic [4:0] K_PLUS   = 5'd11;
    localparam logic [4:0] K_MINUS  = 5'd12;
    localparam logic [4:0] K_ARROW  = 5'd13;
    localparam logic [4:0] K_MUL    = 5'd14;
    localparam logic [4:0] K_DIV    = 5'd15;
    localparam logic [4:0] K_GT     = 5'd16;
    localparam logic [4:0] K_GTE    = 5'd17;
    localparam logic [4:0] K_LT     = 5'd18;
    localparam logic [4:0] K_LTE    = 5'd19;
    localparam logic [4:0] K_EQ     = 5'd20;
    localparam logic [4:0] K_END    = 5'd21;

    // Error codes
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_NESTED_SQ    = 3'd1;
    localparam logic [2:0] ERR_STRAY_SQ     = 3'd2;
    localparam logic [2:0] ERR_STRAY_PAREN  = 3'd3;
    localparam logic [2:0] ERR_STRAY_BRACE  = 3'd4;
    localparam logic [2:0] ERR_UNBALANCED   = 3'd5;
    localparam logic [2:0] ERR_DEPTH        = 3'd6;

    // Character codes
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_LPAR       = 8'h28;
    localparam logic [7:0] CH_RPAR       = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_LT         = 8'h3C;
    localparam logic [7:0] CH_EQ         = 8'h3D;
    localparam logic [7:0] CH_GT         = 8'h3E;
    localparam logic [7:0] CH_LBRACK     = 8'h5B;
    localparam logic [7:0] CH_RBRACK     = 8'h5D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;

    localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;
    localparam logic [15:0] LEN_SAT = 16'hFFFF;

    // One token result as it sits in the output queue
    typedef struct packed
    {
        logic [4:0]  kind;
        logic [23:0] start;
        logic [15:0] len;
        logic [23:0] line;
        logic [30:0] ival;
        logic [2:0]  err;
        logic        last;
    } tok_res_t;

endpackage

[src/qasm_lexer_bracket_check_unit.sv]
// ----------------------------------------------------------------------------
// qasm_lexer_bracket_check_unit: streaming QASM tokenizer with bracket check
// Turns a byte stream into tokens and checks bracket balance on the fly.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (s_axis): one source byte per request in s_axis_tdata[7:0].
//   s_axis_tlast high marks the end of the stream; its byte is ignored, the
//   pending token is flushed and an end token with the balance result follows.
//   Output channel (m_axis): one token per request. tuser carries the token
//   kind, tdata the offset, length, line, integer value and error code, and
//   tlast flags the last token caused by one input request.
// Timing and flow
//   A byte is lexed straight from the input register once the queue has room,
//   and its tokens enter the four-entry result queue at the end of that cycle;
//   m_axis_tvalid is taken from the registered queue count.
//   One byte is taken every cycle as long as the queue keeps two free slots;
//   a byte that closes one token and is a token itself yields two tokens, and
//   the output port then sets the pace at one token per cycle while the receiver is ready.
// Reset and stalls
//   Reset clears the lexer state, the bracket depths, the counters and the
//   queue. When the receiver stalls the queue fills, the input register holds
//   its byte and s_axis_tready drops until two slots are free again.
//   After a bracket error the block drops bytes until the end of the stream.
// ----------------------------------------------------------------------------
module qasm_lexer_bracket_check_unit
#(
    parameter int OFFSET_BITS = 24,
    parameter int LINE_BITS   = 24,
    parameter int DEPTH_BITS  = 16
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] in_byte
    input  logic         s_axis_tlast,   // end_of_input

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [23:0] start_offset, [39:24] token_length, [63:40] start_line,
    // [94:64] int_value, [97:95] error_code, [103:98] zero
    output logic [103:0] m_axis_tdata,
    output logic [4:0]   m_axis_tuser,   // [4:0] token_kind
    output logic         m_axis_tlast    // last
);

    import qlbc_pkg::*;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       consume;

    // ------------------------------------------------------------------
    // Lexer state
    // ------------------------------------------------------------------
    lex_mode_t              mode_reg,        mode_next;
    logic [30:0]            value_accum_reg, value_accum_next;
    logic [OFFSET_BITS-1:0] token_start_reg, token_start_next;
    logic [OFFSET_BITS-1:0] byte_pos_reg,    byte_pos_next;
    logic [15:0]            token_len_reg,   token_len_next;
    logic [LINE_BITS-1:0]   line_count_reg,  line_count_next;
    logic [LINE_BITS-1:0]   token_line_reg,  token_line_next;
    logic                   square_open_reg, square_open_next;
    logic [DEPTH_BITS-1:0]  paren_depth_reg, paren_depth_next;
    logic [DEPTH_BITS-1:0]  brace_depth_reg, brace_depth_next;
    logic [2:0]             sticky_err_reg,  sticky_err_next;

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    tok_res_t   fifo_mem_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] fifo_count_reg;
    logic       pop;
    logic [1:0] push_cnt;
    tok_res_t   slot0;
    tok_res_t   slot1;

    // Holdover item stays until the queue has room for its worst case
    assign consume       = in_valid_reg && (fifo_count_reg <= 3'd2);
    assign s_axis_tready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Widened views of the counters for the fixed 24-bit result fields
    // ------------------------------------------------------------------
    logic [31:0] tok_start_w;
    logic [31:0] byte_pos_w;
    logic [31:0] tok_line_w;
    logic [31:0] line_cnt_w;

    assign tok_start_w = 32'(token_start_reg);
    assign byte_pos_w  = 32'(byte_pos_reg);
    assign tok_line_w  = 32'(token_line_reg);
    assign line_cnt_w  = 32'(line_count_reg);

    // ------------------------------------------------------------------
    // Character classes and the next decimal accumulator value
    // ------------------------------------------------------------------
    logic        is_letter;
    logic        is_digit;
    logic [3:0]  digit_val;
    logic [34:0] acc_x10;
    logic [30:0] acc_digit;
    logic [15:0] len_grow;

    assign is_letter = ((in_byte_reg >= 8'h61) && (in_byte_reg <= 8'h7A))
                    || ((in_byte_reg >= 8'h41) && (in_byte_reg <= 8'h5A));
    assign is_digit  = (in_byte_reg >= 8'h30) && (in_byte_reg <= 8'h39);
    assign digit_val = in_byte_reg[3:0];
    assign acc_x10   = 35'({value_accum_reg, 3'b000}) + 35'({value_accum_reg, 1'b0})
                     + 35'(digit_val);
    assign acc_digit = (acc_x10 > 35'(INT_SAT)) ? INT_SAT : acc_x10[30:0];
    assign len_grow  = (token_len_reg == LEN_SAT) ? LEN_SAT : token_len_reg + 16'd1;

    // ------------------------------------------------------------------
    // Token that a pending mode yields when it ends
    // ------------------------------------------------------------------
    tok_res_t flush_res;
    logic     flush_v;

    always_comb
    begin
        flush_res       = '0;
        flush_res.start = tok_start_w[23:0];
        flush_res.line  = tok_line_w[23:0];
        flush_res.len   = 16'd1;
        flush_v         = 1'b1;
        case (mode_reg)
            M_NAME:
            begin
                flush_res.kind = K_NAME;
                flush_res.len  = token_len_reg;
            end
            M_INT:
            begin
                flush_res.kind = K_INT;
                flush_res.len  = token_len_reg;
                flush_res.ival = value_accum_reg;
            end
            M_REAL:
            begin
                flush_res.kind = K_REAL;
                flush_res.len  = token_len_reg;
                flush_res.ival = value_accum_reg;
            end
            M_MINUS: flush_res.kind = K_MINUS;
            M_SLASH: flush_res.kind = K_DIV;
            M_GT:    flush_res.kind = K_GT;
            M_LT:    flush_res.kind = K_LT;
            default: flush_v = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Main lexer step: pending phase gives result A, idle phase result B
    // ------------------------------------------------------------------
    tok_res_t   res_a;
    tok_res_t   res_b;
    logic       res_a_v;
    logic       res_b_v;
    logic       handled;
    logic       single_v;
    logic [4:0] single_kind;
    logic [2:0] single_err;
    logic [2:0] end_err;
    logic       begin_v;
    lex_mode_t  begin_mode;

    always_comb
    begin
        mode_next        = mode_reg;
        value_accum_next = value_accum_reg;
        token_start_next = token_start_reg;
        byte_pos_next    = byte_pos_reg;
        token_len_next   = token_len_reg;
        line_count_next  = line_count_reg;
        token_line_next  = token_line_reg;
        square_open_next = square_open_reg;
        paren_depth_next = paren_depth_reg;
        brace_depth_next = brace_depth_reg;
        sticky_err_next  = sticky_err_reg;

        res_a       = '0;
        res_b       = '0;
        res_a_v     = 1'b0;
        res_b_v     = 1'b0;
        handled     = 1'b0;
        single_v    = 1'b0;
        single_kind = K_SEMI;
        single_err  = ERR_NONE;
        end_err     = ERR_NONE;
        begin_v     = 1'b0;
        begin_mode  = M_IDLE;

        // Two-character operators, always of length two
        res_a.start = tok_start_w[23:0];
        res_a.line  = tok_line_w[23:0];
        res_a.len   = 16'd2;

        if (consume && in_last_reg)
        begin
            // End of stream: flush, report balance, return to reset state
            if (sticky_err_reg == ERR_NONE)
            begin
                res_a   = flush_res;
                res_a_v = flush_v;
                if (square_open_reg || (paren_depth_reg != '0) || (brace_depth_reg != '0))
                begin
                    end_err = ERR_UNBALANCED;
                end
            end
            else
            begin
                end_err = sticky_err_reg;
            end
            res_b.kind  = K_END;
            res_b.start = byte_pos_w[23:0];
            res_b.line  = line_cnt_w[23:0];
            res_b.err   = end_err;
            res_b_v     = 1'b1;

            mode_next        = M_IDLE;
            value_accum_next = '0;
            token_start_next = '0;
            byte_pos_next    = '0;
            token_len_next   = '0;
            line_count_next  = '0;
            token_line_next  = '0;
            square_open_next = 1'b0;
            paren_depth_next = '0;
            brace_depth_next = '0;
            sticky_err_next  = ERR_NONE;
        end
        else if (consume && (sticky_err_reg == ERR_NONE))
        begin
            byte_pos_next = byte_pos_reg + 1'b1;

            // Pending phase: grow or close the current token
            case (mode_reg)
                M_NAME:
                begin
                    if (is_letter || is_digit || (in_byte_reg == CH_UNDERSCORE)
                        || (in_byte_reg == CH_DOT))
                    begin
                        handled        = 1'b1;
                        token_len_next = len_grow;
                    end
                end
                M_INT:
                begin
                    if (is_digit)
                    begin
                        handled          = 1'b1;
                        token_len_next   = len_grow;
                        value_accum_next = acc_digit;
                    end
                    else if (in_byte_reg == CH_DOT)
                    begin
                        handled        = 1'b1;
                        token_len_next = len_grow;
                        mode_next      = M_REAL;
                    end
                end
                M_REAL:
                begin
                    if (is_digit)
                    begin
                        handled        = 1'b1;
                        token_len_next = len_grow;
                    end
                end
                M_MINUS:
                begin
                    if (in_byte_reg == CH_GT)
                    begin
                        handled    = 1'b1;
                        res_a.kind = K_ARROW;
                        res_a_v    = 1'b1;
                        mode_next  = M_IDLE;
                    end
                end
                M_SLASH:
                begin
                    if (in_byte_reg == CH_SLASH)
                    begin
                        handled   = 1'b1;
                        mode_next = M_COMMENT;
                    end
                end
                M_GT:
                begin
                    if (in_byte_reg == CH_EQ)
                    begin
                        handled    = 1'b1;
                        res_a.kind = K_GTE;
                        res_a_v    = 1'b1;
                        mode_next  = M_IDLE;
                    end
                end
                M_LT:
                begin
                    if (in_byte_reg == CH_EQ)
                    begin
                        handled    = 1'b1;
                        res_a.kind = K_LTE;
                        res_a_v    = 1'b1;
                        mode_next  = M_IDLE;
                    end
                end
                M_EQ:
                begin
                    if (in_byte_reg == CH_EQ)
                    begin
                        handled    = 1'b1;
                        res_a.kind = K_EQ;
                        res_a_v    = 1'b1;
                        mode_next  = M_IDLE;
                    end
                end
                M_COMMENT:
                begin
                    handled = (in_byte_reg != CH_NEWLINE);
                end
                default:
                begin
                    handled = 1'b0;
                end
            endcase

            // Token closed by this byte: flush it, then lex the byte afresh
            if (!handled)
            begin
                if ((mode_reg != M_COMMENT) && (mode_reg != M_IDLE))
                begin
                    res_a   = flush_res;
                    res_a_v = flush_v;
                end
                mode_next = M_IDLE;

                if (is_letter)
                begin
                    begin_v    = 1'b1;
                    begin_mode = M_NAME;
                end
                else if (is_digit)
                begin
                    begin_v    = 1'b1;
                    begin_mode = M_INT;
                end
                else
                begin
                    case (in_byte_reg)
                        CH_NEWLINE: line_count_next = line_count_reg + 1'b1;
                        CH_SEMI:
                        begin
                            single_v    = 1'b1;
                            single_kind = K_SEMI;
                        end
                        CH_LPAR:
                        begin
                            single_v    = 1'b1;
                            single_kind = K_LPAR;
                        end
                        CH_RPAR:
                        begin
                            single_v    = 1'b1;
                            single_kind = K_RPAR;
                        end
                        CH_LBRACK:
                        begin
                            single_v    = 1'b1;
                            single_kind = K_LBRACK;
                        end
                        CH_RBRACK:
                        begin
                            single_v    = 1'b1;
                            single_kind = K_RBRACK;
                        end
                        CH_LBRACE:
                        begin
                            single_v    = 1'b1;
                            single_kind = K_LBRACE;
                        end
                        CH_RBRACE:
                        begin
                            single_v    = 1'b1;
                            single_kind = K_RBRACE;
                        end
                        CH_COMMA:
                        begin
                            single_v    = 1'b1;
                            single_kind = K_COMMA;
                        end
                        CH_PLUS:
                        begin
                            single_v    = 1'b1;
                            single_kind = K_PLUS;
                        end
                        CH_STAR:
                        begin
                            single_v    = 1'b1;
                            single_kind = K_MUL;
                        end
                        CH_MINUS:
                        begin
                            begin_v    = 1'b1;
                            begin_mode = M_MINUS;
                        end
                        CH_SLASH:
                        begin
                            begin_v    = 1'b1;
                            begin_mode = M_SLASH;
                        end
                        CH_GT:
                        begin
                            begin_v    = 1'b1;
                            begin_mode = M_GT;
                        end
                        CH_LT:
                        begin
                            begin_v    = 1'b1;
                            begin_mode = M_LT;
                        end
                        CH_EQ:
                        begin
                            begin_v    = 1'b1;
                            begin_mode = M_EQ;
                        end
                        default: ;
                    endcase
                end

                // Open a multi-character token
                if (begin_v)
                begin
                    mode_next        = begin_mode;
                    token_start_next = byte_pos_reg;
                    token_line_next  = line_count_reg;
                    token_len_next   = 16'd1;
                    value_accum_next = (begin_mode == M_INT) ? 31'(digit_val) : '0;
                end

                // Single-character token with its bracket check
                if (single_v)
                begin
                    case (single_kind)
                        K_LBRACK:
                        begin
                            if (square_open_reg)
                                single_err = ERR_NESTED_SQ;
                            else
                                square_open_next = 1'b1;
                        end
                        K_RBRACK:
                        begin
                            if (!square_open_reg)
                                single_err = ERR_STRAY_SQ;
                            else
                                square_open_next = 1'b0;
                        end
                        K_LPAR:
                        begin
                            if (paren_depth_reg == '1)
                                single_err = ERR_DEPTH;
                            else
                                paren_depth_next = paren_depth_reg + 1'b1;
                        end
                        K_RPAR:
                        begin
                            if (paren_depth_reg == '0)
                                single_err = ERR_STRAY_PAREN;
                            else
                                paren_depth_next = paren_depth_reg - 1'b1;
                        end
                        K_LBRACE:
                        begin
                            if (brace_depth_reg == '1)
                                single_err = ERR_DEPTH;
                            else
                                brace_depth_next = brace_depth_reg + 1'b1;
                        end
                        K_RBRACE:
                        begin
                            if (brace_depth_reg == '0)
                                single_err = ERR_STRAY_BRACE;
                            else
                                brace_depth_next = brace_depth_reg - 1'b1;
                        end
                        default: single_err = ERR_NONE;
                    endcase
                    if (single_err != ERR_NONE)
                    begin
                        sticky_err_next = single_err;
                    end
                    res_b.kind  = single_kind;
                    res_b.start = byte_pos_w[23:0];
                    res_b.len   = 16'd1;
                    res_b.line  = line_cnt_w[23:0];
                    res_b.err   = single_err;
                    res_b_v     = 1'b1;
                end
            end
        end
    end

    // Pack the results into queue order and mark the last one
    always_comb
    begin
        slot0 = res_a_v ? res_a : res_b;
        slot1 = res_b;
        slot0.last = !(res_a_v && res_b_v);
        slot1.last = 1'b1;
        push_cnt   = {1'b0, res_a_v} + {1'b0, res_b_v};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= M_IDLE;
            value_accum_reg <= '0;
            token_start_reg <= '0;
            byte_pos_reg    <= '0;
            token_len_reg   <= '0;
            line_count_reg  <= '0;
            token_line_reg  <= '0;
            square_open_reg <= 1'b0;
            paren_depth_reg <= '0;
            brace_depth_reg <= '0;
            sticky_err_reg  <= ERR_NONE;
        end
        else
        begin
            mode_reg        <= mode_next;
            value_accum_reg <= value_accum_next;
            token_start_reg <= token_start_next;
            byte_pos_reg    <= byte_pos_next;
            token_len_reg   <= token_len_next;
            line_count_reg  <= line_count_next;
            token_line_reg  <= token_line_next;
            square_open_reg <= square_open_next;
            paren_depth_reg <= paren_depth_next;
            brace_depth_reg <= brace_depth_next;
            sticky_err_reg  <= sticky_err_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: up to two writes and one read per cycle
    // ------------------------------------------------------------------
    assign pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_reg + push_cnt;
            rd_ptr_reg     <= rd_ptr_reg + {1'b0, pop};
            fifo_count_reg <= fifo_count_reg + {1'b0, push_cnt} - {2'b00, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            fifo_mem_reg[wr_ptr_reg] <= slot0;
        end
        if (push_cnt == 2'd2)
        begin
            fifo_mem_reg[wr_ptr_reg + 2'd1] <= slot1;
        end
    end

    tok_res_t head;
    assign head = fifo_mem_reg[rd_ptr_reg];

    assign m_axis_tvalid = (fifo_count_reg != 3'd0);
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;
    assign m_axis_tdata  = {6'd0, head.err, head.ival, head.line, head.len, head.start};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count_reg <= 3'd4)
        else $error("result queue overfilled");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        consume && in_last_reg |=> (mode_reg == M_IDLE) && (byte_pos_reg == '0)
            && (paren_depth_reg == '0) && (brace_depth_reg == '0) && !square_open_reg)
        else $error("state not cleared after end of stream");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        consume && !in_last_reg && (sticky_err_reg != ERR_NONE) |-> (push_cnt == 2'd0))
        else $error("token emitted while halted");

    a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
        consume && !in_last_reg && (sticky_err_reg != ERR_NONE)
            |=> $stable(byte_pos_reg) && $stable(sticky_err_reg))
        else $error("state moved while halted");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        consume && in_last_reg |-> res_b_v && (slot1.kind == K_END || slot0.kind == K_END))
        else $error("end of stream gave no end token");

endmodule

[tb/qasm_lexer_bracket_check_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qasm_lexer_bracket_check_unit_tb: self-checking bench for the QASM lexer
// Streams source bytes into the tokenizer under several idle and stall mixes,
// predicts every token with a cycle-free lexer model of its own, and checks
// each token leaving the block, field by field, in order.
// ----------------------------------------------------------------------------
module qasm_lexer_bracket_check_unit_tb;

    import qlbc_pkg::*;

    localparam int  TIMEOUT_CYCLES = 2_000_000;
    localparam int  HOLD_CYCLES    = 400;
    localparam int  DRAIN_CYCLES   = 20;
    localparam int  PHASE_BYTES    = 250;
    localparam int  MAX_REPORTS    = 10;

    // One request on the input channel: a source byte or the end-of-stream mark
    typedef struct packed
    {
        logic [7:0] ch;
        logic       eos;
    } src_item_t;

    logic         clk;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic         s_axis_tlast  = 1'b0;    // end_of_input
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [23:0] start_offset, [39:24] token_length, [63:40] start_line,
    // [94:64] int_value, [97:95] error_code, [103:98] zero
    logic [103:0] m_axis_tdata;
    logic [4:0]   m_axis_tuser;            // [4:0] token_kind
    logic         m_axis_tlast;            // last

    // Stimulus and scoreboard storage
    src_item_t  byte_q[$];       // source bytes waiting to be offered
    tok_res_t   tokens_due[$];   // tokens the lexer must still emit, oldest first
    tok_res_t   step_tokens[$];  // tokens of the request being lexed
    src_item_t  drv_item;
    tok_res_t   got_tok;
    tok_res_t   want_tok;

    bit         req_taken  = 1'b0;
    bit         sink_hold  = 1'b0;
    int         idle_pct   = 0;
    int         stall_pct  = 0;
    int         queued     = 0;
    int         errors     = 0;
    int         cycle_cnt  = 0;

    // Shadow lexer state
    lex_mode_t   lx_mode;
    logic [30:0] lx_accum;
    logic [23:0] lx_tok_start;
    logic [23:0] lx_pos;
    logic [15:0] lx_tok_len;
    logic [23:0] lx_line;
    logic [23:0] lx_tok_line;
    logic        lx_sq_open;
    logic [15:0] lx_paren;
    logic [15:0] lx_brace;
    logic [2:0]  lx_err;

    qasm_lexer_bracket_check_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------------
    function automatic void lexer_clear();
        lx_mode      = M_IDLE;
        lx_accum     = '0;
        lx_tok_start = '0;
        lx_pos       = '0;
        lx_tok_len   = '0;
        lx_line      = '0;
        lx_tok_line  = '0;
        lx_sq_open   = 1'b0;
        lx_paren     = '0;
        lx_brace     = '0;
        lx_err       = ERR_NONE;
    endfunction

    function automatic void put_token(logic [4:0] kind, logic [23:0] start,
                                      logic [15:0] len, logic [23:0] line,
                                      logic [30:0] ival, logic [2:0] err);
        tok_res_t t;
        t.kind  = kind;
        t.start = start;
        t.len   = len;
        t.line  = line;
        t.ival  = ival;
        t.err   = err;
        t.last  = 1'b0;
        step_tokens.insert(step_tokens.size(), t);
    endfunction

    // Emit whatever token is still growing; a lone '=' and a comment emit nothing
    function automatic void flush_token();
        case (lx_mode)
            M_NAME:  put_token(K_NAME, lx_tok_start, lx_tok_len, lx_tok_line, '0, ERR_NONE);
            M_INT:   put_token(K_INT, lx_tok_start, lx_tok_len, lx_tok_line, lx_accum,
                               ERR_NONE);
            M_REAL:  put_token(K_REAL, lx_tok_start, lx_tok_len, lx_tok_line, lx_accum,
                               ERR_NONE);
            M_MINUS: put_token(K_MINUS, lx_tok_start, 16'd1, lx_tok_line, '0, ERR_NONE);
            M_SLASH: put_token(K_DIV, lx_tok_start, 16'd1, lx_tok_line, '0, ERR_NONE);
            M_GT:    put_token(K_GT, lx_tok_start, 16'd1, lx_tok_line, '0, ERR_NONE);
            M_LT:    put_token(K_LT, lx_tok_start, 16'd1, lx_tok_line, '0, ERR_NONE);
            default: ;
        endcase
        lx_mode = M_IDLE;
    endfunction

    // Track bracket depths; return the error this bracket raises, if any
    function automatic logic [2:0] bracket_update(logic [4:0] kind);
        case (kind)
            K_LBRACK:
            begin
                if (lx_sq_open)
                    return ERR_NESTED_SQ;
                lx_sq_open = 1'b1;
            end
            K_RBRACK:
            begin
                if (!lx_sq_open)
                    return ERR_STRAY_SQ;
                lx_sq_open = 1'b0;
            end
            K_LPAR:
            begin
                if (lx_paren == '1)
                    return ERR_DEPTH;
                lx_paren = lx_paren + 16'd1;
            end
            K_RPAR:
            begin
                if (lx_paren == '0)
                    return ERR_STRAY_PAREN;
                lx_paren = lx_paren - 16'd1;
            end
            K_LBRACE:
            begin
                if (lx_brace == '1)
                    return ERR_DEPTH;
                lx_brace = lx_brace + 16'd1;
            end
            K_RBRACE:
            begin
                if (lx_brace == '0)
                    return ERR_STRAY_BRACE;
                lx_brace = lx_brace - 16'd1;
            end
            default: ;
        endcase
        return ERR_NONE;
    endfunction

    function automatic void single_token(logic [4:0] kind, logic [23:0] pos);
        logic [2:0] err;
        err = bracket_update(kind);
        if (err != ERR_NONE)
            lx_err = err;
        put_token(kind, pos, 16'd1, lx_line, '0, err);
    endfunction

    function automatic void open_token(lex_mode_t mode, logic [23:0] pos, logic [30:0] val);
        lx_mode      = mode;
        lx_tok_start = pos;
        lx_tok_line  = lx_line;
        lx_tok_len   = 16'd1;
        lx_accum     = val;
    endfunction

    function automatic bit is_letter(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic void grow_token();
        if (lx_tok_len != LEN_SAT)
            lx_tok_len = lx_tok_len + 16'd1;
    endfunction

    // Start a new token, or act on a byte seen outside any token
    function automatic void lex_fresh(logic [7:0] b, logic [23:0] pos);
        if (is_letter(b))
            open_token(M_NAME, pos, '0);
        else if (is_digit(b))
            open_token(M_INT, pos, 31'(b - "0"));
        else
        begin
            case (b)
                CH_NEWLINE:  lx_line = lx_line + 24'd1;
                CH_SEMI:     single_token(K_SEMI, pos);
                CH_LPAR:     single_token(K_LPAR, pos);
                CH_RPAR:     single_token(K_RPAR, pos);
                CH_LBRACK:   single_token(K_LBRACK, pos);
                CH_RBRACK:   single_token(K_RBRACK, pos);
                CH_LBRACE:   single_token(K_LBRACE, pos);
                CH_RBRACE:   single_token(K_RBRACE, pos);
                CH_COMMA:    single_token(K_COMMA, pos);
                CH_PLUS:     single_token(K_PLUS, pos);
                CH_STAR:     single_token(K_MUL, pos);
                CH_MINUS:    open_token(M_MINUS, pos, '0);
                CH_SLASH:    open_token(M_SLASH, pos, '0);
                CH_GT:       open_token(M_GT, pos, '0);
                CH_LT:       open_token(M_LT, pos, '0);
                CH_EQ:       open_token(M_EQ, pos, '0);
                default:     ;
            endcase
        end
    endfunction

    // Feed a byte to the growing token; return 1 when the byte was consumed
    function automatic bit lex_continue(logic [7:0] b);
        longint unsigned v;
        case (lx_mode)
            M_NAME:
                if (is_letter(b) || is_digit(b) || b == CH_UNDERSCORE || b == CH_DOT)
                begin
                    grow_token();
                    return 1'b1;
                end
            M_INT:
                if (is_digit(b))
                begin
                    grow_token();
                    v = longint'(lx_accum) * 10 + longint'(b - "0");
                    lx_accum = (v > longint'(INT_SAT)) ? INT_SAT : 31'(v);
                    return 1'b1;
                end
                else if (b == CH_DOT)
                begin
                    grow_token();
                    lx_mode = M_REAL;
                    return 1'b1;
                end
            M_REAL:
                if (is_digit(b))
                begin
                    grow_token();
                    return 1'b1;
                end
            M_MINUS:
                if (b == CH_GT)
                begin
                    put_token(K_ARROW, lx_tok_start, 16'd2, lx_tok_line, '0, ERR_NONE);
                    lx_mode = M_IDLE;
                    return 1'b1;
                end
            M_SLASH:
                if (b == CH_SLASH)
                begin
                    lx_mode = M_COMMENT;
                    return 1'b1;
                end
            M_GT:
                if (b == CH_EQ)
                begin
                    put_token(K_GTE, lx_tok_start, 16'd2, lx_tok_line, '0, ERR_NONE);
                    lx_mode = M_IDLE;
                    return 1'b1;
                end
            M_LT:
                if (b == CH_EQ)
                begin
                    put_token(K_LTE, lx_tok_start, 16'd2, lx_tok_line, '0, ERR_NONE);
                    lx_mode = M_IDLE;
                    return 1'b1;
                end
            M_EQ:
                if (b == CH_EQ)
                begin
                    put_token(K_EQ, lx_tok_start, 16'd2, lx_tok_line, '0, ERR_NONE);
                    lx_mode = M_IDLE;
                    return 1'b1;
                end
            M_COMMENT:
            begin
                if (b != CH_NEWLINE)
                    return 1'b1;
                // the newline itself is counted by the fresh-byte path
                lx_mode = M_IDLE;
                return 1'b0;
            end
            default:
            begin
                lx_mode = M_IDLE;
                return 1'b0;
            end
        endcase
        flush_token();
        return 1'b0;
    endfunction

    // Lex one accepted request and queue the tokens it must produce
    function automatic void lex_request(logic [7:0] b, logic eos);
        logic [2:0]  err;
        logic [23:0] pos;
        step_tokens.delete();
        if (eos)
        begin
            err = lx_err;
            if (err == ERR_NONE)
            begin
                flush_token();
                if (lx_sq_open || lx_paren != '0 || lx_brace != '0)
                    err = ERR_UNBALANCED;
            end
            put_token(K_END, lx_pos, 16'd0, lx_line, '0, err);
            lexer_clear();
        end
        else if (lx_err == ERR_NONE)
        begin
            pos    = lx_pos;
            lx_pos = lx_pos + 24'd1;
            if (lx_mode == M_IDLE || !lex_continue(b))
                lex_fresh(b, pos);
        end
        if (step_tokens.size() != 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            tokens_due.insert(tokens_due.size(), step_tokens[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    function automatic void push_byte(logic [7:0] b);
        src_item_t it;
        it.ch  = b;
        it.eos = 1'b0;
        byte_q.insert(byte_q.size(), it);
        queued++;
    endfunction

    // End of stream: the byte beside it is ignored, so make it random
    function automatic void push_end();
        src_item_t it;
        it.ch  = 8'($urandom_range(0, 255));
        it.eos = 1'b1;
        byte_q.insert(byte_q.size(), it);
        queued++;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic void push_run(logic [7:0] b, int n);
        for (int i = 0; i < n; i++)
            push_byte(b);
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1))
            return 8'("a" + $urandom_range(0, 25));
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic void push_digits(int n);
        for (int i = 0; i < n; i++)
            push_byte(rand_digit());
    endfunction

    // One source stream of random tokens, closed by an end-of-stream request.
    // A tidy stream keeps its brackets legal and closes them before the end.
    function automatic void rand_stream(int n_tok, bit tidy);
        string ops[13] = '{";", ",", "+", "*", "-", "/", "->", ">", ">=", "<", "<=",
                           "==", "="};
        int    sq  = 0;
        int    par = 0;
        int    brc = 0;
        int    r;
        int    n;
        for (int k = 0; k < n_tok; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 22)
            begin
                push_byte(rand_letter());
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++)
                begin
                    case ($urandom_range(0, 5))
                        0:       push_byte(CH_UNDERSCORE);
                        1:       push_byte(CH_DOT);
                        2:       push_byte(rand_digit());
                        default: push_byte(rand_letter());
                    endcase
                end
            end
            else if (r < 40)
                // now and then long enough to saturate the value
                push_digits(($urandom_range(0, 19) == 0) ? $urandom_range(10, 14)
                                                          : $urandom_range(1, 5));
            else if (r < 48)
            begin
                push_digits($urandom_range(1, 4));
                push_byte(CH_DOT);
                push_digits($urandom_range(0, 3));
            end
            else if (r < 70)
                push_text(ops[$urandom_range(0, 12)]);
            else if (r < 85)
            begin
                if (!tidy)
                begin
                    case ($urandom_range(0, 5))
                        0:       push_byte(CH_LBRACK);
                        1:       push_byte(CH_RBRACK);
                        2:       push_byte(CH_LPAR);
                        3:       push_byte(CH_RPAR);
                        4:       push_byte(CH_LBRACE);
                        default: push_byte(CH_RBRACE);
                    endcase
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            push_byte(sq != 0 ? CH_RBRACK : CH_LBRACK);
                            sq = 1 - sq;
                        end
                        1:
                            if (par != 0 && (par > 4 || $urandom_range(0, 1)))
                            begin
                                push_byte(CH_RPAR);
                                par--;
                            end
                            else
                            begin
                                push_byte(CH_LPAR);
                                par++;
                            end
                        default:
                            if (brc != 0 && (brc > 4 || $urandom_range(0, 1)))
                            begin
                                push_byte(CH_RBRACE);
                                brc--;
                            end
                            else
                            begin
                                push_byte(CH_LBRACE);
                                brc++;
                            end
                    endcase
                end
            end
            else if (r < 90)
            begin
                // comment body: any byte but newline
                push_text("//");
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++)
                    push_byte(8'($urandom_range(0, 1) ? $urandom_range(11, 255)
                                                      : $urandom_range(0, 9)));
                push_byte(CH_NEWLINE);
            end
            else if (r < 95)
                push_byte(CH_NEWLINE);
            else
                push_byte(8'($urandom_range(0, 255)));

            // separator; none at all lets adjacent tokens run together
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: push_byte(" ");
                5:             push_byte(CH_NEWLINE);
                6:             push_byte(8'h09);
                default:       ;
            endcase
        end
        if (tidy)
        begin
            if (sq != 0)
                push_byte(CH_RBRACK);
            push_run(CH_RPAR, par);
            push_run(CH_RBRACE, brc);
        end
        push_end();
    endfunction

    function automatic void noise_stream();
        int n;
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom_range(0, 255)));
        push_end();
    endfunction

    // Fill one phase's worth of random streams, mostly well formed
    function automatic void rand_phase();
        int start;
        int r;
        start = queued;
        while (queued - start < PHASE_BYTES)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                rand_stream($urandom_range(3, 20), 1'b1);
            else if (r < 9)
                rand_stream($urandom_range(2, 12), 1'b0);
            else
                noise_stream();
        end
    endfunction

    function automatic void directed_streams();
        // stream closed right after reset, nothing in it
        push_end();
        // names, numbers, every operator pair, a comment and a high byte
        push_text("Ab_.9 12.3->>=<=== //x\n;()[]{},+*");
        push_byte(8'hFF);
        push_end();
        // pending single-character tokens flushed by the end
        push_text("7-");
        push_end();
        push_text("/");
        push_end();
        push_text(">");
        push_end();
        push_text("<");
        push_end();
        // lone '=' dropped at the end
        push_text("x=");
        push_end();
        // integer value saturation, also on a real's integer part
        push_text("99999999999 4294967296.5");
        push_end();
        // bracket errors; bytes after the first error are dropped
        push_text("[[");
        push_end();
        push_text("]x");
        push_end();
        push_text(")");
        push_end();
        push_text("}");
        push_end();
        push_text("{");
        push_end();
    endfunction

    // ------------------------------------------------------------------------
    // Input side: offer requests at the falling edge, log acceptances at the
    // rising edge and lex them right there
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || req_taken))
        begin
            req_taken = 1'b0;
            if (byte_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                drv_item = byte_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= drv_item.ch;
                s_axis_tlast  <= drv_item.eos;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            lex_request(s_axis_tdata, s_axis_tlast);
            req_taken = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Output side: stall at random or for a long hold, check every token taken
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !sink_hold && ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_tok.kind  = m_axis_tuser;
            got_tok.start = m_axis_tdata[23:0];
            got_tok.len   = m_axis_tdata[39:24];
            got_tok.line  = m_axis_tdata[63:40];
            got_tok.ival  = m_axis_tdata[94:64];
            got_tok.err   = m_axis_tdata[97:95];
            got_tok.last  = m_axis_tlast;
            if (tokens_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: token with none expected: kind %0d start %0d len %0d",
                             $realtime, got_tok.kind, got_tok.start, got_tok.len);
            end
            else
            begin
                want_tok = tokens_due.pop_front();
                if (got_tok !== want_tok)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                    begin
                        $display("%0t: token mismatch (kind start len line ival err last)",
                                 $realtime);
                        $display("    expected %0d %0d %0d %0d %0d %0d %0d",
                                 want_tok.kind, want_tok.start, want_tok.len, want_tok.line,
                                 want_tok.ival, want_tok.err, want_tok.last);
                        $display("    actual   %0d %0d %0d %0d %0d %0d %0d",
                                 got_tok.kind, got_tok.start, got_tok.len, got_tok.line,
                                 got_tok.ival, got_tok.err, got_tok.last);
                    end
                end
            end
        end
    end

    // Watchdog: ends a hung run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= TIMEOUT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, then phases of idle/stall mixes, then drain and report
    // ------------------------------------------------------------------------
    task automatic drain();
        while (byte_q.size() != 0 || s_axis_tvalid || tokens_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        lexer_clear();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // no idling on either side; the receiver's long hold fills the block
        idle_pct  = 0;
        stall_pct = 0;
        directed_streams();
        drain();
        fork
        begin
            sink_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            sink_hold = 1'b0;
        end
        join_none
        rand_phase();
        drain();

        // sender idle most of the time
        idle_pct  = 64;
        stall_pct = 0;
        rand_phase();
        drain();

        // receiver stalling most of the time
        idle_pct  = 0;
        stall_pct = 64;
        rand_phase();
        drain();

        // both sides idle now and then
        idle_pct  = 24;
        stall_pct = 24;
        rand_phase();
        drain();

        // catch any token the block emits beyond the expected ones
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
src/qlbc_pkg.sv
src/qasm_lexer_bracket_check_unit.sv
tb/qasm_lexer_bracket_check_unit_tb.sv
